// ===== hdl/ckinv_pkg.sv =====
// Shared constants, types and control structs for the chroma key smoothing block.
package ckinv_pkg;

  localparam int LINE_MAX  = 1024;
  localparam int ROWS_MAX  = 4096;
  localparam int WIN_DEPTH = 2 * LINE_MAX + 2;
  localparam int AW        = $clog2(WIN_DEPTH);
  localparam int PIX_W     = 24;
  localparam int IDX_W     = $clog2(LINE_MAX * ROWS_MAX + 1);
  localparam int LW_W      = 11;
  localparam int FH_W      = 13;
  localparam int PEND_W    = 11;
  localparam int NORM_W    = $clog2(IDX_W);
  localparam int CFGI_W    = 3;
  localparam int CFGD_W    = 13;

  // register indexes
  localparam logic [CFGI_W-1:0] CFG_KEY_CB       = 3'd0;
  localparam logic [CFGI_W-1:0] CFG_KEY_CR       = 3'd1;
  localparam logic [CFGI_W-1:0] CFG_ANGLE_TAN    = 3'd2;
  localparam logic [CFGI_W-1:0] CFG_MIN_ACC      = 3'd3;
  localparam logic [CFGI_W-1:0] CFG_LINE_WIDTH   = 3'd4;
  localparam logic [CFGI_W-1:0] CFG_FRAME_HEIGHT = 3'd5;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [7:0]  RST_KEY_CB = 8'd0;
  localparam logic [7:0]  RST_KEY_CR = 8'd127;
  localparam logic [9:0]  RST_TAN    = 10'd85;
  localparam logic [2:0]  RST_MIN    = 3'd1;
  localparam logic [LW_W-1:0] RST_LW = 11'd640;
  localparam logic [FH_W-1:0] RST_FH = 13'd480;
  localparam logic [IDX_W-1:0] RST_N = IDX_W'(640 * 480);

  // floor(x/5) = (x*13108)>>16 for x up to 5*255
  localparam logic [13:0] RECIP5 = 14'd13108;

  typedef enum logic [2:0] {TAP_C, TAP_L, TAP_R, TAP_D, TAP_U} tap_t;

  typedef enum logic [2:0] {ST_IDLE, ST_READ, ST_WAIT, ST_FIN, ST_NMUL, ST_NDIV} state_t;

  typedef struct packed {
    logic take;
    logic cfg_we;
    logic rd_en;
    tap_t tap;
    logic norm_mul;
    logic norm_step;
    logic load_out;
  } ckinv_cmd_t;

  typedef struct packed {
    logic emit;
    logic acc_done;
    logic norm_last;
    logic out_busy;
  } ckinv_sts_t;

endpackage

// ===== hdl/ckinv_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module ckinv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2050
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/ckinv_ctrl.sv =====
// Controller state machine: item intake, neighbour reads, result hand-off, frame size update.
module ckinv_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ckinv_pkg::CFGI_W-1:0]  cfg_index,
  input  ckinv_pkg::ckinv_sts_t         sts,
  output ckinv_pkg::ckinv_cmd_t         cmd
);
  import ckinv_pkg::*;

  state_t state_r, state_nxt;
  tap_t   tap_r, tap_nxt;
  logic   take, cfg_we, size_wr;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign take      = (state_r == ST_IDLE) && in_valid && !cfg_valid;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign size_wr   = cfg_we && ((cfg_index == CFG_LINE_WIDTH) ||
                                (cfg_index == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tap_r   <= TAP_C;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    tap_nxt   = tap_r;
    unique case (state_r)
      ST_IDLE: begin
        tap_nxt = TAP_C;
        if (size_wr) begin
          state_nxt = ST_NMUL;
        end else if (take && sts.emit) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (tap_r == TAP_U) begin
          state_nxt = ST_WAIT;
        end else begin
          tap_nxt = tap_t'(tap_r + 3'd1);
        end
      end
      ST_WAIT: if (sts.acc_done) state_nxt = ST_FIN;
      ST_FIN:  if (!sts.out_busy) state_nxt = ST_IDLE;
      ST_NMUL: state_nxt = ST_NDIV;
      ST_NDIV: if (sts.norm_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.take      = take;
    cmd.cfg_we    = cfg_we;
    cmd.tap       = tap_r;
    unique case (state_r)
      ST_READ: cmd.rd_en     = 1'b1;
      ST_FIN:  cmd.load_out  = !sts.out_busy;
      ST_NMUL: cmd.norm_mul  = 1'b1;
      ST_NDIV: cmd.norm_step = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hdl/ckinv_dp.sv =====
// Datapath: config registers, pixel ring, key test pipeline, accumulators, output register.
module ckinv_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ckinv_pkg::ckinv_cmd_t        cmd,
  output ckinv_pkg::ckinv_sts_t        sts,
  input  logic                         in_cmd,
  input  logic [7:0]                   in_pixel_y,
  input  logic [7:0]                   in_pixel_cb,
  input  logic [7:0]                   in_pixel_cr,
  input  logic [ckinv_pkg::CFGI_W-1:0] cfg_index,
  input  logic [ckinv_pkg::CFGD_W-1:0] cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_y,
  output logic [7:0]                   out_cb,
  output logic [7:0]                   out_cr,
  output logic                         out_was_inverted,
  output logic                         out_frame_end
);
  import ckinv_pkg::*;

  function automatic logic signed [7:0] clamp8(input logic signed [10:0] x);
    if (x < -11'sd128) return -8'sd128;
    if (x > 11'sd127)  return 8'sd127;
    return x[7:0];
  endfunction

  function automatic logic [AW-1:0] wrap(input logic [AW:0] x);
    logic [AW:0] d;
    d = x - (AW+1)'(WIN_DEPTH);
    return (x >= (AW+1)'(WIN_DEPTH)) ? d[AW-1:0] : x[AW-1:0];
  endfunction

  // configuration
  logic signed [7:0] kcb_r, kcr_r;
  logic [9:0]        tan_r;
  logic [2:0]        min_r;
  logic [LW_W-1:0]   lw_r, w_eff;
  logic [FH_W-1:0]   fh_r, h_eff;

  assign w_eff = (lw_r < LW_W'(3)) ? LW_W'(3) :
                 (lw_r > LW_W'(LINE_MAX)) ? LW_W'(LINE_MAX) : lw_r;
  assign h_eff = (fh_r < FH_W'(3)) ? FH_W'(3) :
                 (fh_r > FH_W'(ROWS_MAX)) ? FH_W'(ROWS_MAX) : fh_r;

  // stream position
  logic [IDX_W-1:0]  idx_r, n_r;
  logic [PEND_W-1:0] pend_r, pe_r;
  logic [AW-1:0]     wr_r, slot_r;
  logic [IDX_W-1:0]  fidx_r;
  logic [NORM_W-1:0] k_r;

  logic              is_pix, emit;
  logic [AW-1:0]     wr_inc, wr_cur, slot_nxt;
  logic [IDX_W-1:0]  idx_inc, idx_cur, fidx_nxt;
  logic [PEND_W-1:0] pe;
  logic [IDX_W:0]    ft, ft_sub;
  logic [IDX_W+IDX_W-1:0] dvs;

  assign is_pix  = (in_cmd == CMD_PIXEL);
  assign emit    = is_pix ? (pend_r >= PEND_W'(w_eff)) : (pend_r != '0);
  assign wr_inc  = wrap({1'b0, wr_r} + (AW+1)'(1));
  assign wr_cur  = is_pix ? wr_inc : wr_r;
  assign idx_inc = (idx_r + IDX_W'(1) >= n_r) ? '0 : idx_r + IDX_W'(1);
  assign idx_cur = is_pix ? idx_inc : idx_r;
  assign pe      = is_pix ? pend_r + PEND_W'(1) : pend_r;
  assign slot_nxt = wrap({1'b0, wr_cur} + (AW+1)'(WIN_DEPTH) - (AW+1)'(pe));
  assign ft      = {1'b0, idx_cur} + {1'b0, n_r} - (IDX_W+1)'(pe);
  assign ft_sub  = ft - {1'b0, n_r};
  assign fidx_nxt = (ft >= {1'b0, n_r}) ? ft_sub[IDX_W-1:0] : ft[IDX_W-1:0];
  assign dvs     = (IDX_W+IDX_W)'(n_r) << k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kcb_r  <= RST_KEY_CB;
      kcr_r  <= RST_KEY_CR;
      tan_r  <= RST_TAN;
      min_r  <= RST_MIN;
      lw_r   <= RST_LW;
      fh_r   <= RST_FH;
      idx_r  <= '0;
      pend_r <= '0;
      wr_r   <= '0;
      n_r    <= RST_N;
      k_r    <= '0;
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          CFG_KEY_CB:       kcb_r <= cfg_data[7:0];
          CFG_KEY_CR:       kcr_r <= cfg_data[7:0];
          CFG_ANGLE_TAN:    tan_r <= cfg_data[9:0];
          CFG_MIN_ACC:      min_r <= cfg_data[2:0];
          CFG_LINE_WIDTH:   lw_r  <= cfg_data[LW_W-1:0];
          CFG_FRAME_HEIGHT: fh_r  <= cfg_data[FH_W-1:0];
          default: ;
        endcase
      end
      if (cmd.take) begin
        if (is_pix) begin
          wr_r  <= wr_inc;
          idx_r <= idx_inc;
          if (!emit) pend_r <= pend_r + PEND_W'(1);
        end else if (emit) begin
          pend_r <= pend_r - PEND_W'(1);
        end
      end
      if (cmd.norm_mul) begin
        n_r <= IDX_W'(w_eff * h_eff);
        k_r <= NORM_W'(IDX_W - 1);
      end
      if (cmd.norm_step) begin
        // restoring reduction of the frame position modulo the new frame size
        if ((IDX_W+IDX_W)'(idx_r) >= dvs) idx_r <= idx_r - dvs[IDX_W-1:0];
        k_r <= k_r - NORM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && emit) begin
      slot_r <= slot_nxt;
      fidx_r <= fidx_nxt;
      pe_r   <= pe;
    end
  end

  // ring read address
  logic [AW:0]       off, a_add, a_sub;
  logic [AW-1:0]     raddr;
  logic [PIX_W-1:0]  q;

  always_comb begin
    case (cmd.tap)
      TAP_L, TAP_R: off = (AW+1)'(1);
      TAP_D, TAP_U: off = (AW+1)'(w_eff);
      default:      off = '0;
    endcase
    a_add = {1'b0, slot_r} + off;
    a_sub = {1'b0, slot_r} + (AW+1)'(WIN_DEPTH) - off;
    raddr = ((cmd.tap == TAP_R) || (cmd.tap == TAP_D)) ? wrap(a_add) : wrap(a_sub);
  end

  ckinv_ram #(.WIDTH(PIX_W), .DEPTH(WIN_DEPTH)) u_ring (
    .clk   (clk),
    .we    (cmd.take && is_pix),
    .waddr (wr_r),
    .wdata ({in_pixel_cr, in_pixel_cb, in_pixel_y}),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (q)
  );

  // key test pipeline
  logic              q_vld_r, s1_vld_r, s2_vld_r, s3_vld_r;
  tap_t              q_tap_r, s1_tap_r, s2_tap_r, s3_tap_r;
  logic [7:0]        s1_y_r, s2_y_r, s3_y_r;
  logic signed [16:0] p_bb_r, p_rr_r, p_rb_r, p_br_r;
  logic signed [7:0]  xx_r, yy_r;
  logic signed [14:0] v_r;
  logic [8:0]         ayy_r;
  logic signed [8:0]  cb_s, cr_s;
  logic signed [17:0] sx, sy;
  logic signed [18:0] vp;
  logic signed [14:0] v_c;
  logic [8:0]         ayy_c;
  logic               acc;

  assign cb_s  = $signed({1'b0, q[15:8]});
  assign cr_s  = $signed({1'b0, q[23:16]});
  assign sx    = {p_bb_r[16], p_bb_r} + {p_rr_r[16], p_rr_r};
  assign sy    = {p_rb_r[16], p_rb_r} - {p_br_r[16], p_br_r};
  assign vp    = xx_r * $signed({1'b0, tan_r});
  // v keeps its sign, only capped from above
  assign v_c   = ($signed(vp[18:4]) > 15'sd127) ? 15'sd127 : $signed(vp[18:4]);
  assign ayy_c = yy_r[7] ? (9'd0 - {yy_r[7], yy_r}) : {1'b0, yy_r};
  assign acc   = $signed({1'b0, ayy_r}) < v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r  <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      q_vld_r  <= cmd.rd_en;
      s1_vld_r <= q_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    q_tap_r  <= cmd.tap;
    s1_tap_r <= q_tap_r;
    s2_tap_r <= s1_tap_r;
    s3_tap_r <= s2_tap_r;
    s1_y_r   <= q[7:0];
    s2_y_r   <= s1_y_r;
    s3_y_r   <= s2_y_r;
    p_bb_r   <= cb_s * kcb_r;
    p_rr_r   <= cr_s * kcr_r;
    p_rb_r   <= cr_s * kcb_r;
    p_br_r   <= cb_s * kcr_r;
    xx_r     <= clamp8(sx[17:7]);
    yy_r     <= clamp8(sy[17:7]);
    v_r      <= v_c;
    ayy_r    <= ayy_c;
  end

  // neighbourhood accumulation
  logic [2:0]       cnt_r;
  logic [10:0]      sum_r;
  logic             cacc_r;
  logic [PIX_W-1:0] cpix_r;

  always_ff @(posedge clk) begin
    if (cmd.take && emit) begin
      cnt_r  <= '0;
      sum_r  <= '0;
      cacc_r <= 1'b0;
    end else if (s3_vld_r) begin
      cnt_r <= cnt_r + 3'(acc);
      sum_r <= sum_r + 11'(s3_y_r);
      if (s3_tap_r == TAP_C) cacc_r <= acc;
    end
    if (q_vld_r && (q_tap_r == TAP_C)) cpix_r <= q;
  end

  // result
  logic [24:0]      avg_p;
  logic             proc, smooth, inv;
  logic [7:0]       ry, rcb, rcr;
  logic [IDX_W+1:0] fsum;

  assign avg_p  = sum_r * RECIP5;
  assign fsum   = (IDX_W+2)'(fidx_r) + (IDX_W+2)'(w_eff) + (IDX_W+2)'(2);
  assign proc   = ((PEND_W+1)'(pe_r) >= (PEND_W+1)'(w_eff) + (PEND_W+1)'(1)) &&
                  (fidx_r >= IDX_W'(w_eff) + IDX_W'(1)) &&
                  (fsum <= (IDX_W+2)'(n_r));
  assign smooth = proc && (cnt_r >= min_r);
  assign inv    = smooth && cacc_r;
  assign ry     = smooth ? avg_p[23:16] : cpix_r[7:0];

  always_comb begin
    rcb = cpix_r[15:8];
    rcr = cpix_r[23:16];
    if (inv) begin
      rcb = 8'd255 - cpix_r[15:8];
      rcr = 8'd255 - cpix_r[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_y            <= inv ? 8'd255 - ry : ry;
      out_cb           <= rcb;
      out_cr           <= rcr;
      out_was_inverted <= inv;
      out_frame_end    <= (fidx_r == n_r - IDX_W'(1));
    end
  end

  assign sts.emit      = emit;
  assign sts.acc_done  = s3_vld_r && (s3_tap_r == TAP_U);
  assign sts.norm_last = (k_r == '0);
  assign sts.out_busy  = out_valid;

endmodule

// ===== hdl/chroma_key_smooth_invert.sv =====
// Top level of the chroma key neighbourhood smoothing and inversion block.
// A pixel transaction that releases no result is taken in idle; another may follow next cycle.
// A transaction that releases a pixel reads its five taps through the single read port of the
// pixel ring, passes them through the four-stage key test pipeline and then loads the output
// register; input is held off until then, longer while the previous result still waits on the output.
// Writing line_width or frame_height holds off input during the size multiply and the 23-step reduce.
// Reset (rst_n low, synchronous) restores default registers, drops pending pixels and the output.
module chroma_key_smooth_invert (
  input  logic                         clk,
  input  logic                         rst_n,
  // pixel / flush transactions
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [7:0]                   in_pixel_y,
  input  logic [7:0]                   in_pixel_cb,
  input  logic [7:0]                   in_pixel_cr,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_y,
  output logic [7:0]                   out_cb,
  output logic [7:0]                   out_cr,
  output logic                         out_was_inverted,
  output logic                         out_frame_end,
  // register writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ckinv_pkg::CFGI_W-1:0] cfg_index,
  input  logic [ckinv_pkg::CFGD_W-1:0] cfg_data
);
  import ckinv_pkg::*;

  ckinv_cmd_t cmd;
  ckinv_sts_t sts;

  // controller: decides when transactions are taken and sequences the ring reads
  ckinv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: ring of two lines plus two pixels, key test, averaging, output register
  ckinv_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_cmd           (in_cmd),
    .in_pixel_y       (in_pixel_y),
    .in_pixel_cb      (in_pixel_cb),
    .in_pixel_cr      (in_pixel_cr),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_y            (out_y),
    .out_cb           (out_cb),
    .out_cr           (out_cr),
    .out_was_inverted (out_was_inverted),
    .out_frame_end    (out_frame_end)
  );

  // a finished result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid) else $error("result overwritten");

  // register write and item intake never share a cycle
  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cfg_we |-> !cmd.take) else $error("cfg write during intake");

  // last tap only reaches the accumulators after all ring reads are done
  a_reads_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.acc_done |-> !cmd.rd_en) else $error("read while accumulating");

endmodule
